/* rtl/pidsd_pkg.sv */
// shared types and constants for the pid step with stall detect block
// no dependencies
package pidsd_pkg;

    localparam int ERR_W      = 20;
    localparam int INT_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int WIN_W      = 19;
    localparam int LIM_W      = 15;
    localparam int CNT_W      = 8;
    localparam int DRV_W      = 16;
    localparam int FRAC_BITS  = 8;
    localparam int SUM_W      = 42;
    localparam int Q_W        = SUM_W - FRAC_BITS;
    localparam int CFG_DATA_W = 19;
    localparam int REG_IDX_W  = 3;

    localparam int INTEGRAL_LIMIT = 1048575;

    localparam logic signed [INT_W:0] ACC_MAX = (INT_W + 1)'(INTEGRAL_LIMIT);
    localparam logic signed [INT_W:0] ACC_MIN = -ACC_MAX;

    localparam logic [GAIN_W-1:0] KP_RESET    = GAIN_W'(256);
    localparam logic [GAIN_W-1:0] KI_RESET    = '0;
    localparam logic [GAIN_W-1:0] KD_RESET    = '0;
    localparam logic [WIN_W-1:0]  IWIN_RESET  = '0;
    localparam logic [LIM_W-1:0]  OLIM_RESET  = LIM_W'(12000);
    localparam logic [WIN_W-1:0]  SSTEP_RESET = '0;
    localparam logic [CNT_W-1:0]  SCYC_RESET  = '0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_IWIN  = 3'd3,
        REG_OLIM  = 3'd4,
        REG_SSTEP = 3'd5,
        REG_SCYC  = 3'd6
    } pidsd_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [WIN_W-1:0]  integral_window;
        logic [LIM_W-1:0]  output_limit;
        logic [WIN_W-1:0]  standstill_step;
        logic [CNT_W-1:0]  standstill_cycles;
    } pidsd_cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] error_sample;
        logic                    restart;
    } pidsd_in_t;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive;
        logic                    stalled;
    } pidsd_out_t;

endpackage

/* rtl/pidsd_cfg_regs.sv */
// configuration register file: gains, window, limit and standstill settings
// depends on pidsd_pkg
module pidsd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [pidsd_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [pidsd_pkg::CFG_DATA_W-1:0] cfg_data,
    output pidsd_pkg::pidsd_cfg_t          cfg
);
    import pidsd_pkg::*;

    pidsd_cfg_t cfg_reg;
    pidsd_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (pidsd_reg_t'(cfg_index))
                REG_KP:    cfg_next.kp                = cfg_data[GAIN_W-1:0];
                REG_KI:    cfg_next.ki                = cfg_data[GAIN_W-1:0];
                REG_KD:    cfg_next.kd                = cfg_data[GAIN_W-1:0];
                REG_IWIN:  cfg_next.integral_window   = cfg_data[WIN_W-1:0];
                REG_OLIM:  cfg_next.output_limit      = cfg_data[LIM_W-1:0];
                REG_SSTEP: cfg_next.standstill_step   = cfg_data[WIN_W-1:0];
                REG_SCYC:  cfg_next.standstill_cycles = cfg_data[CNT_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp                <= KP_RESET;
            cfg_reg.ki                <= KI_RESET;
            cfg_reg.kd                <= KD_RESET;
            cfg_reg.integral_window   <= IWIN_RESET;
            cfg_reg.output_limit      <= OLIM_RESET;
            cfg_reg.standstill_step   <= SSTEP_RESET;
            cfg_reg.standstill_cycles <= SCYC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/pidsd_core.sv */
// pid state (previous error, integral, stall count and flag) and the
// single-pass drive and stall computation; depends on pidsd_pkg
module pidsd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  pidsd_pkg::pidsd_in_t  item,
    input  pidsd_pkg::pidsd_cfg_t cfg,
    output pidsd_pkg::pidsd_out_t result
);
    import pidsd_pkg::*;

    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] prev_err_next;
    logic signed [INT_W-1:0] integ_reg;
    logic signed [INT_W-1:0] integ_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    flag_reg;
    logic                    flag_next;

    logic signed [ERR_W-1:0] prev_eff;
    logic signed [INT_W-1:0] integ_eff;
    logic [CNT_W-1:0]        count_eff;
    logic                    flag_eff;

    logic signed [ERR_W:0]   e_ext;
    logic signed [ERR_W:0]   prev_ext;
    logic [ERR_W:0]          abs_e;
    logic signed [ERR_W:0]   deriv;
    logic [ERR_W:0]          abs_d;
    logic signed [INT_W:0]   acc;
    logic signed [INT_W:0]   acc_sat;
    logic                    sign_flip;
    logic                    in_window;

    logic signed [GAIN_W:0]        kp_s;
    logic signed [GAIN_W:0]        ki_s;
    logic signed [GAIN_W:0]        kd_s;
    logic signed [GAIN_W+ERR_W:0]  p_kp;
    logic signed [GAIN_W+INT_W:0]  p_ki;
    logic signed [GAIN_W+ERR_W+1:0] p_kd;
    logic signed [SUM_W-1:0]       sum;
    logic signed [Q_W-1:0]         q;
    logic signed [Q_W-1:0]         lim;
    logic signed [Q_W-1:0]         q_sat;

    logic                    still;
    logic [CNT_W-1:0]        count_inc;

    always_comb
    begin
        prev_eff  = item.restart ? '0 : prev_err_reg;
        integ_eff = item.restart ? '0 : integ_reg;
        count_eff = item.restart ? '0 : count_reg;
        flag_eff  = item.restart ? 1'b0 : flag_reg;

        e_ext    = {item.error_sample[ERR_W-1], item.error_sample};
        prev_ext = {prev_eff[ERR_W-1], prev_eff};
        abs_e    = e_ext[ERR_W] ? (ERR_W + 1)'(-e_ext) : e_ext;
        deriv    = e_ext - prev_ext;
        abs_d    = deriv[ERR_W] ? (ERR_W + 1)'(-deriv) : deriv;

        // integral: cleared on sign change or outside the window
        sign_flip = item.error_sample[ERR_W-1] ^ prev_eff[ERR_W-1];
        in_window = abs_e <= {2'b00, cfg.integral_window};
        acc = {integ_eff[INT_W-1], integ_eff}
            + (INT_W + 1)'(item.error_sample);
        if (acc > ACC_MAX)
            acc_sat = ACC_MAX;
        else if (acc < ACC_MIN)
            acc_sat = ACC_MIN;
        else
            acc_sat = acc;
        if (sign_flip || !in_window)
            integ_next = '0;
        else
            integ_next = acc_sat[INT_W-1:0];

        kp_s = {1'b0, cfg.kp};
        ki_s = {1'b0, cfg.ki};
        kd_s = {1'b0, cfg.kd};
        p_kp = kp_s * item.error_sample;
        p_ki = ki_s * integ_next;
        p_kd = kd_s * deriv;
        sum  = SUM_W'(p_kp) + SUM_W'(p_ki) + SUM_W'(p_kd);

        // floor shift then clamp to the output limit
        q   = Q_W'(sum >>> FRAC_BITS);
        lim = Q_W'({1'b0, cfg.output_limit});
        if (q > lim)
            q_sat = lim;
        else if (q < -lim)
            q_sat = -lim;
        else
            q_sat = q;

        still     = (cfg.standstill_cycles != '0) && (abs_d <= {2'b00, cfg.standstill_step});
        count_inc = (count_eff == {CNT_W{1'b1}}) ? count_eff : count_eff + 1'b1;
        if (still)
        begin
            count_next = count_inc;
            flag_next  = flag_eff | (count_inc > cfg.standstill_cycles);
        end
        else
        begin
            count_next = '0;
            flag_next  = flag_eff;
        end

        prev_err_next = item.error_sample;

        result.drive   = q_sat[DRV_W-1:0];
        result.stalled = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            integ_reg    <= '0;
            count_reg    <= '0;
            flag_reg     <= 1'b0;
        end
        else if (step)
        begin
            prev_err_reg <= prev_err_next;
            integ_reg    <= integ_next;
            count_reg    <= count_next;
            flag_reg     <= flag_next;
        end
    end

endmodule

/* rtl/pid_step_with_stall_detect.sv */
// pid step with stall detect: top level with input and result registers
// depends on pidsd_pkg, pidsd_cfg_regs, pidsd_core
//
// usage
//   sample channel: sample_valid / sample_stall / sample carry one error item
//   per control tick; an item is taken at a clock edge with valid high and
//   stall low. result channel: result_valid / result_stall / result give the
//   drive value and stall flag, one result item per sample item, in order.
//   config port: cfg_write with cfg_index and cfg_data writes one register;
//   write only while no item is in flight.
// result path
//   an accepted item is registered in the input register, passes the core
//   and is registered in the result register; one item per cycle while the
//   result is not held by result_stall. the state loop (previous error,
//   integral, stall count) closes through the core, which sets that rate.
// reset
//   rst_n low clears both pipeline valid flags and the pid state and loads
//   the register defaults; sample_stall is held high while in reset.
// receiver stall
//   a held result stays stable; one more item waits in the input register,
//   after which sample_stall rises until the result is taken.
module pid_step_with_stall_detect (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  pidsd_pkg::pidsd_in_t             sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output pidsd_pkg::pidsd_out_t            result,
    input  logic                             cfg_write,
    input  logic [pidsd_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [pidsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pidsd_pkg::*;

    pidsd_cfg_t cfg;
    pidsd_out_t core_result;

    logic       in_valid_reg;
    logic       in_valid_next;
    pidsd_in_t  in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    pidsd_out_t out_item_reg;

    logic       out_free;
    logic       advance;
    logic       take;

    pidsd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidsd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    always_comb
    begin
        out_free       = !out_valid_reg || !result_stall;
        advance        = in_valid_reg && out_free;
        sample_stall   = !rst_n || (in_valid_reg && !out_free);
        take           = sample_valid && !sample_stall;
        in_valid_next  = take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= sample;
        if (advance)
            out_item_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

/* rtl/pidsd_checker.sv */
// port-level checks for pid_step_with_stall_detect, bound to the top level
// depends on pidsd_pkg
module pidsd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sample_valid,
    input logic                  sample_stall,
    input logic                  result_valid,
    input logic                  result_stall,
    input pidsd_pkg::pidsd_out_t result
);
    import pidsd_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result item dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result item changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rst_n && sample_stall |-> result_valid && result_stall)
        else $error("sample stalled without a blocked result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_valid && !sample_stall, 2))
        else $error("result item without an accepted sample item");

endmodule

bind pid_step_with_stall_detect pidsd_checker u_pidsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

/* test/pid_step_with_stall_detect_tb.sv */
// testbench for pid_step_with_stall_detect: directed and random error items
// checked against an in-bench drive and stall flag predictor
// depends on pidsd_pkg and the pid_step_with_stall_detect rtl
`timescale 1ns / 1ps

module pid_step_with_stall_detect_tb;

    import pidsd_pkg::*;

    class drive_scoreboard;
        int         kp_gain;
        int         ki_gain;
        int         kd_gain;
        int         int_window;
        int         out_limit;
        int         still_step;
        int         still_cycles;

        int         last_err;
        int         integ;
        int         still_count;
        bit         stall_seen;

        pidsd_out_t pending_results[$];
        int         fail_count;

        function new();
            kp_gain      = int'(KP_RESET);
            ki_gain      = int'(KI_RESET);
            kd_gain      = int'(KD_RESET);
            int_window   = int'(IWIN_RESET);
            out_limit    = int'(OLIM_RESET);
            still_step   = int'(SSTEP_RESET);
            still_cycles = int'(SCYC_RESET);
            last_err     = 0;
            integ        = 0;
            still_count  = 0;
            stall_seen   = 1'b0;
            fail_count   = 0;
        endfunction

        function void write_reg(pidsd_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_KP:    kp_gain      = int'(data[GAIN_W-1:0]);
                REG_KI:    ki_gain      = int'(data[GAIN_W-1:0]);
                REG_KD:    kd_gain      = int'(data[GAIN_W-1:0]);
                REG_IWIN:  int_window   = int'(data[WIN_W-1:0]);
                REG_OLIM:  out_limit    = int'(data[LIM_W-1:0]);
                REG_SSTEP: still_step   = int'(data[WIN_W-1:0]);
                REG_SCYC:  still_cycles = int'(data[CNT_W-1:0]);
                default:   ;
            endcase
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // predict drive and stall flag for one accepted item
        function void take_sample(pidsd_in_t s);
            int         e;
            longint     acc;
            longint     deriv;
            longint     sum;
            longint     q;
            pidsd_out_t res;
            e = int'($signed(s.error_sample));
            if (s.restart)
            begin
                last_err    = 0;
                integ       = 0;
                still_count = 0;
                stall_seen  = 1'b0;
            end
            if ((e < 0) != (last_err < 0))
                integ = 0;
            else if (mag(e) <= int_window)
            begin
                acc = longint'(integ) + e;
                if (acc > INTEGRAL_LIMIT)
                    acc = INTEGRAL_LIMIT;
                if (acc < -longint'(INTEGRAL_LIMIT))
                    acc = -longint'(INTEGRAL_LIMIT);
                integ = int'(acc);
            end
            else
                integ = 0;
            deriv = longint'(e) - last_err;
            sum = longint'(kp_gain) * e + longint'(ki_gain) * integ
                + longint'(kd_gain) * deriv;
            q = sum >>> FRAC_BITS;
            if (q > out_limit)
                q = out_limit;
            if (q < -longint'(out_limit))
                q = -longint'(out_limit);
            if (still_cycles != 0 && mag(longint'(last_err) - e) <= still_step)
            begin
                if (still_count < 255)
                    still_count++;
                if (still_count > still_cycles)
                    stall_seen = 1'b1;
            end
            else
                still_count = 0;
            last_err    = e;
            res.drive   = q[DRV_W-1:0];
            res.stalled = stall_seen;
            pending_results.push_back(res);
        endfunction

        function void check_result(pidsd_out_t got);
            pidsd_out_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result item drive %0d stalled %0b",
                         $time, got.drive, got.stalled);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.drive !== want.drive)
            begin
                $display("%0t: drive mismatch, expected %0d, actual %0d",
                         $time, want.drive, got.drive);
                fail_count++;
            end
            if (got.stalled !== want.stalled)
            begin
                $display("%0t: stalled mismatch, expected %0b, actual %0b",
                         $time, want.stalled, got.stalled);
                fail_count++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    pidsd_in_t             sample;
    logic                  result_valid;
    logic                  result_stall;
    pidsd_out_t            result;
    logic                  cfg_write;
    logic [REG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    drive_scoreboard sb;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              hold_cycles_req;
    int              walk_err;
    int              walk_span;
    int              phase_idx;

    pid_step_with_stall_detect i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold_cycles_req) @(posedge clk);
                hold_cycles_req = 0;
            end
            result_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                sb.take_sample(sample);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    function automatic pidsd_in_t make_item(input int e, input bit rs);
        pidsd_in_t s;
        s.error_sample = e[ERR_W-1:0];
        s.restart      = rs;
        return s;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(1024));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic pidsd_cfg_t pick_config();
        pidsd_cfg_t c;
        c.kp = pick_gain();
        c.ki = pick_gain();
        c.kd = pick_gain();
        case ($urandom_range(3))
            0:       c.integral_window = '0;
            1:       c.integral_window = '1;
            2:       c.integral_window = WIN_W'($urandom_range(4096));
            default: c.integral_window = WIN_W'($urandom);
        endcase
        case ($urandom_range(3))
            0:       c.output_limit = '0;
            1:       c.output_limit = '1;
            default: c.output_limit = LIM_W'($urandom);
        endcase
        case ($urandom_range(4))
            0:       c.standstill_step = '0;
            1:       c.standstill_step = '1;
            default: c.standstill_step = WIN_W'($urandom_range(64));
        endcase
        case ($urandom_range(4))
            0:       c.standstill_cycles = '0;
            1:       c.standstill_cycles = '1;
            2:       c.standstill_cycles = CNT_W'(1);
            default: c.standstill_cycles = CNT_W'($urandom_range(12, 2));
        endcase
        return c;
    endfunction

    // mostly a random walk with standstills, some noise around zero and full range
    function automatic pidsd_in_t next_item();
        int e;
        int pick;
        pick = $urandom_range(99);
        e = walk_err;
        if (pick < 60)
            e = walk_err + int'($urandom_range(2 * walk_span)) - walk_span;
        else if (pick < 88 && pick >= 75)
            e = int'($urandom_range(64)) - 32;
        else if (pick >= 88)
            e = int'($urandom_range(20'hFFFFF)) - 524288;
        if (e > 524287)
            e = 524287;
        if (e < -524288)
            e = -524288;
        walk_err = e;
        return make_item(e, $urandom_range(99) < 3);
    endfunction

    task automatic send_item(input pidsd_in_t s);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (sample_stall);
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input pidsd_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_config(input pidsd_cfg_t c);
        put_reg(REG_KP, CFG_DATA_W'(c.kp));
        put_reg(REG_KI, CFG_DATA_W'(c.ki));
        put_reg(REG_KD, CFG_DATA_W'(c.kd));
        put_reg(REG_IWIN, CFG_DATA_W'(c.integral_window));
        put_reg(REG_OLIM, CFG_DATA_W'(c.output_limit));
        put_reg(REG_SSTEP, CFG_DATA_W'(c.standstill_step));
        put_reg(REG_SCYC, CFG_DATA_W'(c.standstill_cycles));
        cfg_write <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
            3:       begin send_idle_pct = 14; recv_stall_pct = 14; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic run_random_phase(input int n_items, input int mode, input int hold);
        int k;
        apply_config(pick_config());
        set_idling(mode);
        case ($urandom_range(3))
            0:       walk_span = 2;
            1:       walk_span = 64;
            2:       walk_span = 4096;
            default: walk_span = 200000;
        endcase
        hold_cycles_req = hold;
        for (k = 0; k < n_items; k++)
            send_item(next_item());
        drain_results();
    endtask

    initial
    begin
        pidsd_cfg_t c;
        sb              = new();
        rst_n           = 1'b0;
        sample_valid    = 1'b0;
        sample          = '0;
        cfg_write       = 1'b0;
        cfg_index       = REG_KP;
        cfg_data        = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_cycles_req = 0;
        walk_err        = 0;
        walk_span       = 64;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults: plain proportional, clamp at the default limit
        send_item(make_item(0, 1'b0));
        send_item(make_item(524287, 1'b0));
        send_item(make_item(-524288, 1'b0));
        send_item(make_item(-1, 1'b0));
        send_item(make_item(5, 1'b1));
        drain_results();

        // full gains: integral saturation both ways, sign change, zero, stall and restart
        c.kp                = '1;
        c.ki                = '1;
        c.kd                = '1;
        c.integral_window   = '1;
        c.output_limit      = '1;
        c.standstill_step   = '0;
        c.standstill_cycles = CNT_W'(1);
        apply_config(c);
        repeat (3) send_item(make_item(524287, 1'b0));
        send_item(make_item(-524288, 1'b0));
        repeat (3) send_item(make_item(-400000, 1'b0));
        send_item(make_item(0, 1'b0));
        send_item(make_item(0, 1'b0));
        send_item(make_item(7, 1'b1));
        drain_results();

        // zero output limit, widest standstill step, largest cycle count
        c.ki                = '0;
        c.integral_window   = '0;
        c.output_limit      = '0;
        c.standstill_step   = '1;
        c.standstill_cycles = '1;
        apply_config(c);
        send_item(make_item(100, 1'b0));
        send_item(make_item(-100, 1'b0));
        send_item(make_item(524287, 1'b1));
        send_item(make_item(-524288, 1'b0));
        drain_results();

        for (phase_idx = 0; phase_idx < 8; phase_idx++)
            run_random_phase(100, phase_idx % 4, (phase_idx == 4) ? 60 : 0);

        set_idling(0);
        drain_results();
        repeat (4) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
